@@ rtl/sst_pkg.sv @@
// ============================================================================
// Session slot table package
// Item and result types, status codes and sequencer states shared by the
// front end, the back end and the top level.
// ============================================================================
package sst_pkg;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_NEW   = 3'd0,
        ST_REACT = 3'd1,
        ST_LIVE  = 3'd2,
        ST_FULL  = 3'd3,
        ST_OUT   = 3'd4,
        ST_NONE  = 3'd5
    } sst_status_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_EXEC,
        BK_FINISH
    } sst_state_t;

    // Classified request as it travels through the queue.
    typedef struct packed {
        logic        is_logout;
        logic [63:0] user_key;
        logic [15:0] descriptor;
        logic [31:0] seg_index;
    } sst_item_t;

    // Result beat before packing onto the output stream.
    typedef struct packed {
        sst_status_t status;
        logic [3:0]  slot;
        logic [15:0] stored_descriptor;
        logic [31:0] stored_seg_index;
        logic [4:0]  live_count;
    } sst_result_t;

endpackage

@@ rtl/session_slot_table.sv @@
// ============================================================================
// Session slot table
// Keyed login and logout table with a fixed number of slots.
// ============================================================================
// Each request beat is a login or a logout for a user key. A login finds the
// key and reactivates it, rejects it when already live, or allocates the
// lowest unused slot; a logout marks the entry not live and stores the
// segment index. Every request yields exactly one result beat carrying the
// status, slot, stored descriptor and segment index, and the live count.
// The back end walks the key store one slot per cycle through its single read
// port, stopping at the first match, then updates the slot and forms the
// result. A two-entry queue in front keeps taking requests while one is in
// progress, and the result register lets the next request start while a
// result waits to be taken. Slot flags are cleared by reset at once, so no
// clearing pass is needed.
module session_slot_table
    import sst_pkg::*;
#(
    parameter int MAX_USERS = 16,
    parameter int KEY_BYTES = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // user_key[63:0], descriptor[79:64], seg_index[111:80]
    input  logic [111:0] s_tdata,
    // operation[0]
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // slot[3:0], stored_descriptor[19:4], stored_seg_index[51:20],
    // live_count[56:52], zero[63:57]
    output logic [63:0]  m_tdata,
    // status[2:0]
    output logic [2:0]   m_tuser
);

    logic        q_valid;
    logic        q_ready;
    sst_item_t   q_item;
    sst_result_t res;

    sst_front #(
        .KEY_BYTES (KEY_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    sst_back #(
        .MAX_USERS (MAX_USERS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // Pack the result beat onto the output stream.
    assign m_tdata = {7'd0, res.live_count, res.stored_seg_index,
                      res.stored_descriptor, res.slot};
    assign m_tuser = res.status;

endmodule

@@ rtl/sst_queue.sv @@
// ============================================================================
// Session slot table request queue
// Two-entry queue that decouples request intake from table processing.
// ============================================================================
module sst_queue
    import sst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  sst_item_t push_item,
    output logic      pop_valid,
    input  logic      pop_ready,
    output sst_item_t pop_item
);

    sst_item_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    // Handshake on both sides.
    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/sst_front.sv @@
// ============================================================================
// Session slot table front end
// Accepts request beats, decodes the operation, trims the key to its
// significant bytes and queues the request for the back end.
// ============================================================================
module sst_front
    import sst_pkg::*;
#(
    parameter int KEY_BYTES = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,
    input  logic [0:0]   s_tuser,
    output logic         q_valid,
    input  logic         q_ready,
    output sst_item_t    q_item
);

    localparam logic [63:0] KEY_MASK =
        64'hFFFF_FFFF_FFFF_FFFF >> (7'd64 - 7'(8 * KEY_BYTES));

    sst_item_t in_item;

    // Classify the incoming beat; only the low key bytes take part in matching.
    always_comb
    begin
        in_item.is_logout  = s_tuser[0];
        in_item.user_key   = s_tdata[63:0] & KEY_MASK;
        in_item.descriptor = s_tdata[79:64];
        in_item.seg_index  = s_tdata[111:80];
    end

    sst_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_item  (in_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

endmodule

@@ rtl/sst_back.sv @@
// ============================================================================
// Session slot table back end
// Scans the key store one slot per cycle, applies the login or logout to
// the matched or first free slot and holds the result beat.
// ============================================================================
module sst_back
    import sst_pkg::*;
#(
    parameter int MAX_USERS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_ready,
    input  sst_item_t   q_item,
    output logic        res_valid,
    input  logic        res_ready,
    output sst_result_t res
);

    localparam int IDX_W = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
    localparam int CNT_W = $clog2(MAX_USERS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_USERS - 1);
    localparam logic [CNT_W-1:0] ISSUE_END = CNT_W'(MAX_USERS);

    // Slot storage.
    logic [63:0] key_mem  [MAX_USERS];
    logic [15:0] desc_mem [MAX_USERS];
    logic [31:0] seg_mem  [MAX_USERS];
    logic [MAX_USERS-1:0] used_reg;
    logic [MAX_USERS-1:0] live_reg;
    logic [CNT_W-1:0]     live_total_reg;

    // Sequencer and scan state.
    sst_state_t       state_reg;
    sst_state_t       state_next;
    sst_item_t        item_reg;
    logic [CNT_W-1:0] issue_reg;
    logic             rd_valid_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [63:0]      key_rd_reg;
    logic             hit_found_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;

    // Execution results.
    sst_status_t      status_reg;
    logic [IDX_W-1:0] target_reg;
    logic [15:0]      desc_rd_reg;
    logic [31:0]      seg_rd_reg;
    sst_result_t      res_reg;
    logic             res_valid_reg;

    logic cmp_hit;
    logic cmp_free;
    logic scan_last;
    logic issue_ok;
    logic take_item;
    logic in_scan;
    logic in_exec;
    logic load_res;

    // Execution decision.
    sst_status_t      ex_status;
    logic [IDX_W-1:0] ex_target;
    logic             ex_alloc;
    logic             ex_set_live;
    logic             ex_clr_live;
    logic             ex_inc;
    logic             ex_dec;
    logic             ex_wr_seg;

    sst_result_t      res_build;
    logic [IDX_W+3:0] slot_ext;
    logic [CNT_W+4:0] live_ext;

    // Compare stage of the scan pipeline.
    assign cmp_hit   = rd_valid_reg && used_reg[rd_idx_reg] &&
                       (key_rd_reg == item_reg.user_key);
    assign cmp_free  = rd_valid_reg && !used_reg[rd_idx_reg];
    assign scan_last = rd_valid_reg && (rd_idx_reg == LAST_IDX);
    assign issue_ok  = (issue_reg != ISSUE_END);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = BK_SCAN;
                end
            end
            BK_SCAN:
            begin
                if (cmp_hit || scan_last)
                begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                state_next = BK_FINISH;
            end
            BK_FINISH:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // State-decoded control outputs.
    always_comb
    begin
        q_ready  = 1'b0;
        in_scan  = 1'b0;
        in_exec  = 1'b0;
        load_res = 1'b0;
        unique case (state_reg)
            BK_IDLE:   q_ready  = 1'b1;
            BK_SCAN:   in_scan  = 1'b1;
            BK_EXEC:   in_exec  = 1'b1;
            BK_FINISH: load_res = !res_valid_reg || res_ready;
            default:   q_ready  = 1'b0;
        endcase
    end

    assign take_item = q_ready && q_valid;

    // Decide what the request does once the scan is over.
    always_comb
    begin
        ex_status   = ST_NONE;
        ex_target   = hit_found_reg ? hit_idx_reg : free_idx_reg;
        ex_alloc    = 1'b0;
        ex_set_live = 1'b0;
        ex_clr_live = 1'b0;
        ex_inc      = 1'b0;
        ex_dec      = 1'b0;
        ex_wr_seg   = 1'b0;
        priority if (item_reg.is_logout)
        begin
            if (hit_found_reg)
            begin
                ex_status   = ST_OUT;
                ex_wr_seg   = 1'b1;
                ex_clr_live = live_reg[hit_idx_reg];
                ex_dec      = live_reg[hit_idx_reg];
            end
            else
            begin
                ex_status = ST_NONE;
            end
        end
        else if (hit_found_reg)
        begin
            if (live_reg[hit_idx_reg])
            begin
                ex_status = ST_LIVE;
            end
            else
            begin
                ex_status   = ST_REACT;
                ex_set_live = 1'b1;
                ex_inc      = 1'b1;
            end
        end
        else if (free_found_reg)
        begin
            ex_status   = ST_NEW;
            ex_alloc    = 1'b1;
            ex_set_live = 1'b1;
            ex_inc      = 1'b1;
        end
        else
        begin
            ex_status = ST_FULL;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            issue_reg      <= '0;
            rd_valid_reg   <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            used_reg       <= '0;
            live_reg       <= '0;
            live_total_reg <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (take_item)
            begin
                issue_reg      <= '0;
                rd_valid_reg   <= 1'b0;
                hit_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (in_scan)
            begin
                rd_valid_reg <= issue_ok;
                if (issue_ok)
                begin
                    issue_reg <= issue_reg + CNT_W'(1);
                end
                if (cmp_hit)
                begin
                    hit_found_reg <= 1'b1;
                end
                if (cmp_free && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
            end
            if (in_exec)
            begin
                if (ex_alloc)
                begin
                    used_reg[ex_target] <= 1'b1;
                end
                if (ex_set_live)
                begin
                    live_reg[ex_target] <= 1'b1;
                end
                else if (ex_clr_live)
                begin
                    live_reg[ex_target] <= 1'b0;
                end
                if (ex_inc)
                begin
                    live_total_reg <= live_total_reg + CNT_W'(1);
                end
                else if (ex_dec)
                begin
                    live_total_reg <= live_total_reg - CNT_W'(1);
                end
            end
            if (load_res)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers of the scan and execute steps.
    always_ff @(posedge clk)
    begin
        if (take_item)
        begin
            item_reg <= q_item;
        end
        if (in_scan)
        begin
            rd_idx_reg <= issue_reg[IDX_W-1:0];
            if (cmp_hit)
            begin
                hit_idx_reg <= rd_idx_reg;
            end
            if (cmp_free && !free_found_reg)
            begin
                free_idx_reg <= rd_idx_reg;
            end
        end
        if (in_exec)
        begin
            status_reg <= ex_status;
            target_reg <= ex_target;
        end
        if (load_res)
        begin
            res_reg <= res_build;
        end
    end

    // Key store: one read per scan cycle, written on allocation.
    always_ff @(posedge clk)
    begin
        if (in_scan && issue_ok)
        begin
            key_rd_reg <= key_mem[issue_reg[IDX_W-1:0]];
        end
        if (in_exec && ex_alloc)
        begin
            key_mem[ex_target] <= item_reg.user_key;
        end
    end

    // Descriptor and segment stores: read and updated at the target slot.
    always_ff @(posedge clk)
    begin
        if (in_exec)
        begin
            desc_rd_reg <= desc_mem[ex_target];
            seg_rd_reg  <= seg_mem[ex_target];
            if (ex_alloc)
            begin
                desc_mem[ex_target] <= item_reg.descriptor;
                seg_mem[ex_target]  <= '0;
            end
            else if (ex_wr_seg)
            begin
                seg_mem[ex_target] <= item_reg.seg_index;
            end
        end
    end

    // Assemble the result beat; fresh writes override the stale reads.
    assign slot_ext = {4'd0, target_reg};
    assign live_ext = {5'd0, live_total_reg};

    always_comb
    begin
        res_build.status            = status_reg;
        res_build.slot              = slot_ext[3:0];
        res_build.stored_descriptor = desc_rd_reg;
        res_build.stored_seg_index  = seg_rd_reg;
        res_build.live_count        = live_ext[4:0];
        unique case (status_reg)
            ST_NEW:
            begin
                res_build.stored_descriptor = item_reg.descriptor;
                res_build.stored_seg_index  = '0;
            end
            ST_OUT:
            begin
                res_build.stored_seg_index = item_reg.seg_index;
            end
            ST_FULL, ST_NONE:
            begin
                res_build.slot              = '0;
                res_build.stored_descriptor = '0;
                res_build.stored_seg_index  = '0;
            end
            ST_REACT, ST_LIVE:
            begin
                res_build.stored_descriptor = desc_rd_reg;
            end
            default:
            begin
                res_build.slot = '0;
            end
        endcase
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
